@@ sv/srsm_pkg.sv @@
`default_nettype none

package srsm_pkg;

	// pattern geometry
	localparam int MAX_PATTERN = 16;
	localparam int LIVE_W      = MAX_PATTERN + 1;
	localparam int PAT_BYTES   = 16;
	localparam int PAT_W       = 8 * PAT_BYTES;
	localparam int CNT_W       = 5;
	localparam int TOK_IDX_W   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_PAT_LEN  = 2'd2
	} cfg_reg_t;

	// special pattern characters
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ANY    = 8'h2E;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [1:0] {
		TOK_LIT  = 2'd0,
		TOK_STAR = 2'd1,
		TOK_END  = 2'd2
	} tok_kind_t;

	typedef enum logic [1:0] {
		SCAN_IDLE = 2'd0,
		SCAN_LOAD = 2'd1,
		SCAN_RUN  = 2'd2
	} scan_state_t;

endpackage

`default_nettype wire

@@ sv/simple_regex_stream_matcher.sv @@
// Channel  | Direction | Payload (low bit up)          | Transfer
// s_*      | in        | s_tdata: text_byte[7:0]       | s_tvalid & s_tready
// m_*      | out       | m_tdata: matched[0], zero pad | m_tvalid & m_tready
// cfg_*    | in        | cfg_index[1:0], cfg_data[63:0]| cfg_valid & cfg_ready
//
// One text byte per cycle while s_tready is high; the live-position update sits
// between the input transfer and the output register, so the result of a zero
// byte shows in the cycle after its transfer.
// Each configuration write starts a pattern scan (a load state, then a run
// state that enters the pattern tokens into the token table until the pattern
// ends) during which s_tready is low.
// Reset clears the pattern to empty and rearms for a new string.
// A stalled result holds the input side until the result transfers.
`default_nettype none

module simple_regex_stream_matcher (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // text_byte[7:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [7:0]                           m_tdata,   // matched[0], zeros [7:1]
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [srsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [srsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srsm_pkg::*;

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [CNT_W-1:0]      pat_len_q;

	// token table built by the scan
	tok_kind_t             tok_kind_q [MAX_PATTERN];
	logic [7:0]            tok_char_q [MAX_PATTERN];
	logic [CNT_W-1:0]      tok_count_q;
	logic                  anchored_q;

	// scan sequencer
	scan_state_t           scan_state_q, scan_state_d;
	logic [PAT_W-1:0]      scan_buf_q;
	logic [CNT_W-1:0]      scan_rem_q;
	logic                  scan_idle;

	// matcher state
	logic [LIVE_W-1:0]     live_q;
	logic                  at_start_q;
	logic                  match_seen_q;

	// output register
	logic                  out_valid_q;
	logic                  out_matched_q;

	logic                  cfg_xfer;
	logic                  in_xfer;
	logic                  out_xfer;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign out_xfer  = out_valid_q & m_tready;
	assign s_tready  = scan_idle & ~cfg_valid & (~out_valid_q | m_tready);
	assign in_xfer   = s_tvalid & s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {7'd0, out_matched_q};

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				CFG_PAT_HIGH: pat_high_q <= cfg_data;
				CFG_PAT_LEN:  pat_len_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// scan step: classify the token at the head of the buffer
	logic [7:0]       sc_c, sc_c1;
	logic             sc_stop;
	tok_kind_t        sc_kind;
	logic             sc_two;

	always_comb begin
		sc_c    = scan_buf_q[7:0];
		sc_c1   = scan_buf_q[15:8];
		sc_stop = (scan_rem_q == '0) || (sc_c == CH_NUL);
		sc_two  = 1'b0;
		if ((scan_rem_q >= CNT_W'(2)) && (sc_c1 == CH_STAR)) begin
			sc_kind = TOK_STAR;
			sc_two  = 1'b1;
		end else if ((sc_c == CH_DOLLAR) &&
				((scan_rem_q == CNT_W'(1)) || (sc_c1 == CH_NUL))) begin
			sc_kind = TOK_END;
		end else begin
			sc_kind = TOK_LIT;
		end
	end

	// load values: clamp length, strip a leading anchor
	logic [PAT_W-1:0] ld_pat;
	logic [CNT_W-1:0] ld_len;
	logic             ld_anchor;

	always_comb begin
		ld_pat    = {pat_high_q, pat_low_q};
		ld_len    = (pat_len_q > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : pat_len_q;
		ld_anchor = (ld_len != '0) && (ld_pat[7:0] == CH_CARET);
	end

	// scan next state
	always_comb begin
		scan_state_d = scan_state_q;
		if (cfg_xfer) begin
			scan_state_d = SCAN_LOAD;
		end else begin
			unique case (scan_state_q)
				SCAN_IDLE: scan_state_d = SCAN_IDLE;
				SCAN_LOAD: scan_state_d = SCAN_RUN;
				SCAN_RUN:  scan_state_d = sc_stop ? SCAN_IDLE : SCAN_RUN;
				default:   scan_state_d = SCAN_IDLE;
			endcase
		end
	end

	// scan outputs
	always_comb begin
		unique case (scan_state_q)
			SCAN_IDLE: scan_idle = 1'b1;
			default:   scan_idle = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state_q <= SCAN_IDLE;
			tok_count_q  <= '0;
			anchored_q   <= 1'b0;
		end else begin
			scan_state_q <= scan_state_d;
			if (!cfg_xfer && scan_state_q == SCAN_LOAD) begin
				anchored_q  <= ld_anchor;
				tok_count_q <= '0;
			end else if (!cfg_xfer && scan_state_q == SCAN_RUN && !sc_stop) begin
				tok_count_q <= tok_count_q + CNT_W'(1);
			end
		end
	end

	// scan buffer and token table
	always_ff @(posedge clk) begin
		if (scan_state_q == SCAN_LOAD) begin
			if (ld_anchor) begin
				scan_buf_q <= ld_pat >> 8;
				scan_rem_q <= ld_len - CNT_W'(1);
			end else begin
				scan_buf_q <= ld_pat;
				scan_rem_q <= ld_len;
			end
		end else if (scan_state_q == SCAN_RUN && !sc_stop) begin
			tok_kind_q[tok_count_q[TOK_IDX_W-1:0]] <= sc_kind;
			tok_char_q[tok_count_q[TOK_IDX_W-1:0]] <= sc_c;
			if (sc_two) begin
				scan_buf_q <= scan_buf_q >> 16;
				scan_rem_q <= scan_rem_q - CNT_W'(2);
			end else begin
				scan_buf_q <= scan_buf_q >> 8;
				scan_rem_q <= scan_rem_q - CNT_W'(1);
			end
		end
	end

	// seed, star closure and advance for one text byte
	logic [LIVE_W-1:0] live_seed;
	logic [LIVE_W-1:0] star_ext;
	logic [LIVE_W-1:0] live_cl;
	logic [LIVE_W-1:0] run_mask;
	logic [LIVE_W-1:0] live_next;
	logic              hit_full;
	logic              hit_end;
	logic              char_ok;
	logic [TOK_IDX_W-1:0] last_idx;

	always_comb begin
		if (at_start_q) begin
			live_seed = LIVE_W'(1);
		end else begin
			live_seed = live_q | (anchored_q ? '0 : LIVE_W'(1));
		end

		star_ext = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			star_ext[i] = (tok_kind_q[i] == TOK_STAR) && (CNT_W'(i) < tok_count_q);
		end

		// position j is live if some live i <= j reaches it through star tokens
		live_cl = '0;
		for (int j = 0; j < LIVE_W; j++) begin
			for (int i = 0; i <= j; i++) begin
				run_mask = (LIVE_W'(1) << j) - (LIVE_W'(1) << i);
				if (live_seed[i] && (&(star_ext | ~run_mask))) begin
					live_cl[j] = 1'b1;
				end
			end
		end

		hit_full = live_cl[tok_count_q];
		last_idx = TOK_IDX_W'(tok_count_q - CNT_W'(1));
		hit_end  = (tok_count_q != '0) && (tok_kind_q[last_idx] == TOK_END) &&
			live_cl[{1'b0, last_idx}];

		live_next = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			char_ok = (tok_char_q[i] == CH_ANY) || (tok_char_q[i] == s_tdata);
			if ((CNT_W'(i) < tok_count_q) && live_cl[i] && char_ok) begin
				case (tok_kind_q[i])
					TOK_LIT:  live_next[i+1] = 1'b1;
					TOK_STAR: live_next[i]   = 1'b1;
					default: ;
				endcase
			end
		end
	end

	// update matcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			at_start_q   <= 1'b1;
			match_seen_q <= 1'b0;
		end else if (in_xfer) begin
			if (s_tdata == CH_NUL) begin
				live_q       <= '0;
				at_start_q   <= 1'b1;
				match_seen_q <= 1'b0;
			end else begin
				live_q       <= live_next;
				at_start_q   <= 1'b0;
				match_seen_q <= match_seen_q | hit_full;
			end
		end
	end

	// load or drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && s_tdata == CH_NUL) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_tdata == CH_NUL) begin
			out_matched_q <= match_seen_q | hit_full | hit_end;
		end
	end

endmodule

`default_nettype wire

@@ sv/srsm_checker.sv @@
`default_nettype none

module srsm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [7:0]                      s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [7:0]                      m_tdata,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready
);
	import srsm_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a terminating byte gives a result next cycle
	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata == CH_NUL |=> m_tvalid)
		else $error("no result after terminating byte");

	// a text byte never invents a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata != CH_NUL && !m_tvalid |=> !m_tvalid)
		else $error("result without terminating byte");

	// a configuration transfer starts a pattern scan that holds the input
	a_cfg_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("input taken during pattern scan");

	// keep padding bits clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("nonzero padding in result");

endmodule

bind simple_regex_stream_matcher srsm_checker u_srsm_checker (.*);

`default_nettype wire
